// File: rtl/mmc1_pkg.sv
// ----------------------------------------------------------------------------
// mmc1_pkg
// Shared types and constants of the serial bank mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package mmc1_pkg;

	localparam int OFFSET_BITS = 19;
	localparam logic [18:0] OFS_MASK = 19'((64'd1 << OFFSET_BITS) - 64'd1);

	// access kinds
	localparam logic [1:0] FUNC_CPU_RD = 2'd0;
	localparam logic [1:0] FUNC_CPU_WR = 2'd1;
	localparam logic [1:0] FUNC_PPU_RD = 2'd2;
	localparam logic [1:0] FUNC_PPU_WR = 2'd3;

	// targets
	localparam logic [2:0] TGT_NONE    = 3'd0;
	localparam logic [2:0] TGT_PRG_ROM = 3'd1;
	localparam logic [2:0] TGT_PRG_RAM = 3'd2;
	localparam logic [2:0] TGT_CHR_ROM = 3'd3;
	localparam logic [2:0] TGT_CHR_RAM = 3'd4;

	// configuration register indexes
	localparam logic [1:0] CFG_PRG_LOG2 = 2'd0;
	localparam logic [1:0] CFG_CHR_RAM  = 2'd1;
	localparam logic [1:0] CFG_CHR_LOG2 = 2'd2;
	localparam logic [1:0] CFG_MIRROR   = 2'd3;

	// serial register select, address bits 14:13
	localparam logic [1:0] SEL_CONTROL = 2'd0;
	localparam logic [1:0] SEL_CHR0    = 2'd1;
	localparam logic [1:0] SEL_CHR1    = 2'd2;
	localparam logic [1:0] SEL_PRG     = 2'd3;

	localparam logic [4:0] CONTROL_RESET = 5'h0C;
	localparam logic [2:0] LOG2_MAX      = 3'd5;
	localparam logic [2:0] MIRROR_MAX    = 3'd4;
	localparam logic [2:0] MIRROR_RESET  = 3'd3;
	localparam logic [2:0] LOAD_LAST     = 3'd4;

	typedef struct packed {
		logic [4:0] control;
		logic [4:0] chr0;
		logic [4:0] chr1;
		logic [4:0] prg;
		logic [2:0] prg_log2;
		logic       chr_ram;
		logic [2:0] chr_log2;
	} mmc1_state_t;

	typedef struct packed {
		logic [2:0]  target;
		logic [18:0] mem_offset;
		logic        wr_en;
		logic        open_bus;
		logic        write_rejected;
	} mmc1_res_t;

	function automatic logic [2:0] clamp3(input logic [2:0] v, input logic [2:0] hi);
		clamp3 = (v > hi) ? hi : v;
	endfunction

endpackage

`default_nettype wire

// File: rtl/mmc1_if.sv
// ----------------------------------------------------------------------------
// mmc1 channel interfaces
// Bus access request, translation result and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface mmc1_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [15:0] address;
	logic [7:0]  write_data;

	modport source (output valid, func, address, write_data, input ready);
	modport sink   (input valid, func, address, write_data, output ready);
endinterface

interface mmc1_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  target;
	logic [18:0] mem_offset;
	logic        wr_en;
	logic        open_bus;
	logic        write_rejected;
	logic [2:0]  mirror_mode;

	modport source (output valid, target, mem_offset, wr_en, open_bus,
		write_rejected, mirror_mode, input ready);
	modport sink   (input valid, target, mem_offset, wr_en, open_bus,
		write_rejected, mirror_mode, output ready);
endinterface

interface mmc1_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [2:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/mmc1_serial_bank_mapper.sv
// Throughput: one request per cycle when the result side does not stall;
// input stage, then translate into result register.
// Result register stalls hold the input stage; both sides pipeline freely otherwise.
// Reset (arst_n low): pipeline empty, control 0x0C, banks and loader zero,
// mirroring horizontal, configuration at its defaults.
// ----------------------------------------------------------------------------
// mmc1_serial_bank_mapper
// Serial-loaded cartridge bank mapper translating CPU and PPU bus accesses.
// ----------------------------------------------------------------------------
`default_nettype none

module mmc1_serial_bank_mapper (
	input  wire logic clk,
	input  wire logic arst_n,
	mmc1_in_if.sink   req,
	mmc1_out_if.source rsp,
	mmc1_cfg_if.sink  cfg
);
	import mmc1_pkg::*;

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	logic        out_valid_q;
	mmc1_res_t   res_q;
	logic [2:0]  mirror_q;

	logic        adv;
	mmc1_state_t state;
	mmc1_res_t   res;
	logic [2:0]  mirror_next;

	assign adv       = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv;

	mmc1_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.step        (adv),
		.func        (func_s1),
		.address     (addr_s1),
		.write_data  (data_s1),
		.state       (state),
		.mirror_next (mirror_next)
	);

	mmc1_xlate u_xlate (
		.func    (func_s1),
		.address (addr_s1),
		.state   (state),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (req.valid && req.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			func_s1 <= req.func;
			addr_s1 <= req.address;
			data_s1 <= req.write_data;
		end
		if (adv) begin
			res_q    <= res;
			mirror_q <= mirror_next;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.target         = res_q.target;
	assign rsp.mem_offset     = res_q.mem_offset;
	assign rsp.wr_en          = res_q.wr_en;
	assign rsp.open_bus       = res_q.open_bus;
	assign rsp.write_rejected = res_q.write_rejected;
	assign rsp.mirror_mode    = mirror_q;

`ifndef NO_ASSERTIONS
	a_none_no_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && (rsp.target == TGT_NONE)) |-> (rsp.mem_offset == '0))
		else $error("offset set without a target");

	a_reject_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.write_rejected) |-> (!rsp.wr_en && (rsp.target == TGT_NONE)))
		else $error("rejected write still targets memory");

	a_open_bus_none: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.open_bus) |-> (rsp.target == TGT_NONE))
		else $error("open bus with a target");

	a_write_ram_only: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.wr_en) |->
		((rsp.target == TGT_PRG_RAM) || (rsp.target == TGT_CHR_RAM)))
		else $error("memory write to a read-only target");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !rsp.ready) |-> !req.ready)
		else $error("request taken while both stages are full");
`endif

endmodule

`default_nettype wire

// File: rtl/mmc1_regs.sv
// ----------------------------------------------------------------------------
// mmc1_regs
// Mapper state: serial loader, bank registers, mirroring and configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module mmc1_regs (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	mmc1_cfg_if.sink                  cfg,
	input  wire logic                 step,
	input  wire logic [1:0]           func,
	input  wire logic [15:0]          address,
	input  wire logic [7:0]           write_data,
	output mmc1_pkg::mmc1_state_t     state,
	output logic [2:0]                mirror_next
);
	import mmc1_pkg::*;

	logic [4:0] control_q, chr0_q, chr1_q, prg_q, shift_q;
	logic [2:0] count_q, mirror_q, prg_log2_q, chr_log2_q;
	logic       chr_ram_q;

	logic       reg_wr, commit;
	logic [4:0] shift_new;

	assign cfg.ready = 1'b1;

	assign reg_wr    = step && (func == FUNC_CPU_WR) && address[15];
	assign shift_new = shift_q | (5'(write_data[0]) << count_q);
	assign commit    = reg_wr && !write_data[7] && (count_q == LOAD_LAST);

	always_comb begin
		if (commit && (address[14:13] == SEL_CONTROL)) begin
			mirror_next = {1'b0, shift_new[1:0]};
		end else begin
			mirror_next = mirror_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			control_q  <= CONTROL_RESET;
			chr0_q     <= '0;
			chr1_q     <= '0;
			prg_q      <= '0;
			shift_q    <= '0;
			count_q    <= '0;
			mirror_q   <= MIRROR_RESET;
			prg_log2_q <= 3'd1;
			chr_ram_q  <= 1'b0;
			chr_log2_q <= 3'd1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_PRG_LOG2: prg_log2_q <= clamp3(cfg.data, LOG2_MAX);
				CFG_CHR_RAM:  chr_ram_q  <= cfg.data[0];
				CFG_CHR_LOG2: chr_log2_q <= clamp3(cfg.data, LOG2_MAX);
				CFG_MIRROR:   mirror_q   <= clamp3(cfg.data, MIRROR_MAX);
			endcase
		end else if (reg_wr) begin
			if (write_data[7]) begin
				shift_q   <= '0;
				count_q   <= '0;
				control_q <= control_q | CONTROL_RESET;
			end else if (commit) begin
				shift_q  <= '0;
				count_q  <= '0;
				mirror_q <= mirror_next;
				unique case (address[14:13])
					SEL_CONTROL: control_q <= shift_new;
					SEL_CHR0:    chr0_q    <= shift_new;
					SEL_CHR1:    chr1_q    <= shift_new;
					SEL_PRG:     prg_q     <= shift_new;
				endcase
			end else begin
				shift_q <= shift_new;
				count_q <= count_q + 3'd1;
			end
		end
	end

	assign state = '{control: control_q, chr0: chr0_q, chr1: chr1_q, prg: prg_q,
		prg_log2: prg_log2_q, chr_ram: chr_ram_q, chr_log2: chr_log2_q};

endmodule

`default_nettype wire

// File: rtl/mmc1_xlate.sv
// ----------------------------------------------------------------------------
// mmc1_xlate
// Address translation of one bus access against the current mapper state.
// ----------------------------------------------------------------------------
`default_nettype none

module mmc1_xlate (
	input  wire logic [1:0]           func,
	input  wire logic [15:0]          address,
	input  wire mmc1_pkg::mmc1_state_t state,
	output mmc1_pkg::mmc1_res_t       res
);
	import mmc1_pkg::*;

	logic        extended, block, rb, hi;
	logic [3:0]  bank;
	logic [4:0]  cbank;
	logic [16:0] coff, chr_mask;
	logic [18:0] prg_mask, offset;

	assign extended = (state.prg_log2 == LOG2_MAX);
	assign block    = extended & state.chr0[4];
	assign rb       = extended & state.chr0[3];
	assign hi       = address[14];
	assign prg_mask = ~(19'h7FFFF << (5'd14 + 5'(state.prg_log2)));
	assign chr_mask = ~(17'h1FFFF << (5'd12 + 5'(state.chr_log2)));

	always_comb begin
		unique case (state.control[3:2])
			2'd0, 2'd1: bank = {state.prg[3:1], hi};
			2'd2:       bank = hi ? state.prg[3:0] : 4'd0;
			2'd3:       bank = hi ? 4'hF : state.prg[3:0];
		endcase
	end

	always_comb begin
		if (!state.control[4]) begin
			cbank = {state.chr0[4:1], address[12]};
		end else if (!address[12]) begin
			cbank = state.chr0;
		end else begin
			cbank = state.chr1;
		end
		coff = {cbank, address[11:0]} & chr_mask;
	end

	always_comb begin
		res    = '0;
		offset = '0;
		if (!func[1]) begin
			if (address < 16'h6000) begin
				res.target = TGT_NONE;
			end else if (!address[15]) begin
				if (state.prg[4]) begin
					res.open_bus = (func == FUNC_CPU_RD);
				end else begin
					res.target = TGT_PRG_RAM;
					offset     = {5'd0, rb, address[12:0]};
					res.wr_en  = (func == FUNC_CPU_WR);
				end
			end else if (func == FUNC_CPU_RD) begin
				res.target = TGT_PRG_ROM;
				offset     = {block, bank, address[13:0]} & prg_mask;
			end
		end else if ((func == FUNC_PPU_WR) && !state.chr_ram) begin
			res.write_rejected = 1'b1;
		end else begin
			res.target = state.chr_ram ? TGT_CHR_RAM : TGT_CHR_ROM;
			offset     = {2'b00, coff};
			res.wr_en  = (func == FUNC_PPU_WR);
		end
		res.mem_offset = offset & OFS_MASK;
	end

endmodule

`default_nettype wire

// File: tb/mmc1_serial_bank_mapper_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmc1_serial_bank_mapper_test
// Self-checking bench for the serial bank mapper. A behavioral translator
// predicts target, offset, flags and mirroring for every accepted bus access.
// Each result is compared field by field against the oldest prediction.
// Runs directed corners, serial register loads and random traffic over several
// cartridge settings. Both sides idle at random, and one long output stall
// backs up the input.
// ----------------------------------------------------------------------------

module mmc1_serial_bank_mapper_test;
	import mmc1_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam logic [1:0] PRG_FIX_FIRST = 2'd2;

	typedef struct packed {
		logic [2:0]  target;
		logic [18:0] mem_offset;
		logic        wr_en;
		logic        open_bus;
		logic        write_rejected;
		logic [2:0]  mirror_mode;
	} xlate_t;

	logic clk;
	logic arst_n;

	mmc1_in_if  bus_req ();
	mmc1_out_if xlate_rsp ();
	mmc1_cfg_if cfg_wr ();

	mmc1_serial_bank_mapper DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (bus_req),
		.rsp    (xlate_rsp),
		.cfg    (cfg_wr)
	);

	// mapper state as the bench sees it
	logic [4:0] ctl_q, chr0_q, chr1_q, prg_q, shift_q;
	logic [2:0] count_q;
	logic [3:0] prgsel_q;
	logic [2:0] mirror_q;
	logic [2:0] prg_log2_q, chr_log2_q, hdr_mirror_q;
	logic       chr_ram_q;

	xlate_t expected_xlate [$];
	int n_requests, n_checked, n_errors, n_settings;
	int tx_idle, rx_idle, hold_left, longest_hold;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results pending", cycles,
			expected_xlate.size());
		$display("tb: failure");
		$finish;
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic void reset_translator();
		prg_log2_q   = 3'd1;
		chr_ram_q    = 1'b0;
		chr_log2_q   = 3'd1;
		hdr_mirror_q = MIRROR_RESET;
		mirror_q     = MIRROR_RESET;
		ctl_q        = CONTROL_RESET;
		chr0_q       = '0;
		chr1_q       = '0;
		prg_q        = '0;
		shift_q      = '0;
		count_q      = '0;
		prgsel_q     = '0;
	endfunction

	function automatic void apply_setting(input logic [1:0] idx, input logic [2:0] v);
		case (idx)
			CFG_PRG_LOG2: prg_log2_q = (v > LOG2_MAX) ? LOG2_MAX : v;
			CFG_CHR_RAM:  chr_ram_q = v[0];
			CFG_CHR_LOG2: chr_log2_q = (v > LOG2_MAX) ? LOG2_MAX : v;
			CFG_MIRROR: begin
				hdr_mirror_q = (v > MIRROR_MAX) ? MIRROR_MAX : v;
				mirror_q = hdr_mirror_q;
			end
			default: ;
		endcase
	endfunction

	function automatic void commit_serial(input logic [1:0] sel, input logic [4:0] v);
		case (sel)
			SEL_CONTROL: begin
				ctl_q = v;
				mirror_q = {1'b0, v[1:0]};
			end
			SEL_CHR0: chr0_q = v;
			SEL_CHR1: chr1_q = v;
			default: begin
				prg_q = v;
				prgsel_q = v[3:0];
			end
		endcase
	endfunction

	// translate one bus access and advance the mapper state
	function automatic xlate_t translate_access(input logic [1:0] f, input logic [15:0] a,
		input logic [7:0] d);
		xlate_t r;
		logic ext;
		logic [3:0] bank;
		logic [4:0] loaded;
		logic [12:0] pa;
		logic [31:0] ofs, lim;
		r = '0;
		ofs = '0;
		ext = (prg_log2_q >= LOG2_MAX);
		if (f == FUNC_CPU_RD || f == FUNC_CPU_WR) begin
			if (a < 16'h6000) begin
				r = '0;
			end else if (a < 16'h8000) begin
				if (prg_q[4]) begin
					r.open_bus = (f == FUNC_CPU_RD);
				end else begin
					r.target = TGT_PRG_RAM;
					ofs = ((ext && chr0_q[3]) ? 32'h2000 : 32'h0) + 32'(a - 16'h6000);
					r.wr_en = (f == FUNC_CPU_WR);
				end
			end else if (f == FUNC_CPU_RD) begin
				if (!ctl_q[3])
					bank = {prgsel_q[3:1], a[14]};
				else if (ctl_q[3:2] == PRG_FIX_FIRST)
					bank = a[14] ? prgsel_q : 4'h0;
				else
					bank = a[14] ? 4'hF : prgsel_q;
				lim = (32'h4000 << prg_log2_q) - 32'd1;
				r.target = TGT_PRG_ROM;
				ofs = {13'd0, ext & chr0_q[4], bank, a[13:0]} & lim;
			end else if (d[7]) begin
				shift_q = '0;
				count_q = '0;
				ctl_q = ctl_q | CONTROL_RESET;
			end else begin
				loaded = shift_q | (5'(d[0]) << count_q);
				if (count_q == LOAD_LAST) begin
					commit_serial(a[14:13], loaded);
					shift_q = '0;
					count_q = '0;
				end else begin
					shift_q = loaded;
					count_q = count_q + 3'd1;
				end
			end
		end else begin
			pa = a[12:0];
			lim = (32'h1000 << chr_log2_q) - 32'd1;
			if (!ctl_q[4])
				ofs = 32'({chr0_q[4:1], 1'b0}) * 32'h1000 + 32'(pa);
			else if (!pa[12])
				ofs = 32'(chr0_q) * 32'h1000 + 32'(pa);
			else
				ofs = 32'(chr1_q) * 32'h1000 + 32'(pa[11:0]);
			ofs = ofs & lim;
			if (f == FUNC_PPU_WR && !chr_ram_q) begin
				r.write_rejected = 1'b1;
				ofs = '0;
			end else begin
				r.target = chr_ram_q ? TGT_CHR_RAM : TGT_CHR_ROM;
				r.wr_en = (f == FUNC_PPU_WR);
			end
		end
		r.mem_offset = ofs[18:0] & OFS_MASK;
		r.mirror_mode = mirror_q;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		n_errors++;
		if (n_errors <= 40)
			$display("mismatch %s at result %0d: got 0x%0h want 0x%0h", what, n_checked,
				got, want);
	endtask

	always @(posedge clk) begin : check_results
		xlate_t got, want;
		if (arst_n && xlate_rsp.valid && xlate_rsp.ready) begin
			got.target         = xlate_rsp.target;
			got.mem_offset     = xlate_rsp.mem_offset;
			got.wr_en          = xlate_rsp.wr_en;
			got.open_bus       = xlate_rsp.open_bus;
			got.write_rejected = xlate_rsp.write_rejected;
			got.mirror_mode    = xlate_rsp.mirror_mode;
			if (expected_xlate.size() == 0) begin
				report_mismatch("unrequested result", 32'(got), 32'd0);
			end else begin
				want = expected_xlate.pop_front();
				if (got.target !== want.target)
					report_mismatch("target", 32'(got.target), 32'(want.target));
				if (got.mem_offset !== want.mem_offset)
					report_mismatch("mem_offset", 32'(got.mem_offset),
						32'(want.mem_offset));
				if (got.wr_en !== want.wr_en)
					report_mismatch("wr_en", 32'(got.wr_en), 32'(want.wr_en));
				if (got.open_bus !== want.open_bus)
					report_mismatch("open_bus", 32'(got.open_bus), 32'(want.open_bus));
				if (got.write_rejected !== want.write_rejected)
					report_mismatch("write_rejected", 32'(got.write_rejected),
						32'(want.write_rejected));
				if (got.mirror_mode !== want.mirror_mode)
					report_mismatch("mirror_mode", 32'(got.mirror_mode),
						32'(want.mirror_mode));
			end
			n_checked++;
		end
	end

	// result side: random stalls plus an optional long hold
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		xlate_rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				xlate_rsp.ready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				xlate_rsp.ready <= 1'b0;
				stall_left--;
			end else begin
				xlate_rsp.ready <= 1'b1;
				if (rx_idle != 0 && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	task automatic send_access(input logic [1:0] f, input logic [15:0] a, input logic [7:0] d);
		int gap;
		gap = (tx_idle != 0 && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
		if (gap > 0) begin
			bus_req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		bus_req.valid      <= 1'b1;
		bus_req.func       <= f;
		bus_req.address    <= a;
		bus_req.write_data <= d;
		do @(posedge clk); while (!bus_req.ready);
		expected_xlate.push_back(translate_access(f, a, d));
		n_requests++;
	endtask

	// five serial writes, LSB first; bit 7 stays clear, bits 6:1 are don't-care
	task automatic load_register(input logic [1:0] sel, input logic [4:0] v);
		for (int i = 0; i < 5; i++)
			send_access(FUNC_CPU_WR, {1'b1, sel, 13'($urandom)},
				{1'b0, 6'($urandom), v[i]});
	endtask

	task automatic drain_results();
		bus_req.valid <= 1'b0;
		do @(posedge clk); while (expected_xlate.size() != 0);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic [2:0] v);
		cfg_wr.valid <= 1'b1;
		cfg_wr.index <= idx;
		cfg_wr.data  <= v;
		do @(posedge clk); while (!cfg_wr.ready);
		apply_setting(idx, v);
	endtask

	task automatic write_config(input logic [2:0] prg_log2, input logic [2:0] chr_ram,
		input logic [2:0] chr_log2, input logic [2:0] mirror);
		drain_results();
		write_register(CFG_PRG_LOG2, prg_log2);
		write_register(CFG_CHR_RAM, chr_ram);
		write_register(CFG_CHR_LOG2, chr_log2);
		write_register(CFG_MIRROR, mirror);
		cfg_wr.valid <= 1'b0;
		n_settings++;
	endtask

	task automatic random_access();
		int pick;
		pick = $urandom_range(0, 11);
		case (pick)
			0, 1, 2: begin
				if ($urandom_range(0, 1) == 0)
					send_access(FUNC_CPU_WR, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
				load_register(2'($urandom), 5'($urandom));
			end
			3: send_access(FUNC_CPU_WR, {1'b1, 15'($urandom)}, {1'b1, 7'($urandom)});
			4: send_access($urandom_range(0, 1) ? FUNC_CPU_WR : FUNC_CPU_RD,
				{3'b011, 13'($urandom)}, 8'($urandom));
			5, 6: send_access(FUNC_CPU_RD, {1'b1, 15'($urandom)}, 8'($urandom));
			7, 8: send_access($urandom_range(0, 1) ? FUNC_PPU_WR : FUNC_PPU_RD,
				{3'b000, 13'($urandom)}, 8'($urandom));
			9: send_access(FUNC_CPU_WR, {1'b1, 15'($urandom)}, {1'b0, 7'($urandom)});
			default: send_access(2'($urandom), 16'($urandom), 8'($urandom));
		endcase
	endtask

	task automatic run_random(input int n_items);
		int first;
		first = n_requests;
		while (n_requests - first < n_items)
			random_access();
	endtask

	task automatic test_reset_state();
		send_access(FUNC_CPU_RD, 16'h0000, 8'h00);
		send_access(FUNC_CPU_WR, 16'h5FFF, 8'hFF);
		send_access(FUNC_CPU_RD, 16'h6000, 8'h00);
		send_access(FUNC_CPU_WR, 16'h7FFF, 8'hA5);
		send_access(FUNC_CPU_RD, 16'h8000, 8'h00);
		send_access(FUNC_CPU_RD, 16'hFFFF, 8'h00);
		send_access(FUNC_PPU_RD, 16'h0000, 8'h00);
		send_access(FUNC_PPU_RD, 16'hFFFF, 8'h00);
		send_access(FUNC_PPU_WR, 16'h1000, 8'h5A);
	endtask

	task automatic test_serial_loading();
		send_access(FUNC_CPU_WR, 16'h8000, 8'h80);
		// PRG bit 4 disables the RAM window
		load_register(SEL_PRG, 5'h10);
		send_access(FUNC_CPU_RD, 16'h6000, 8'h00);
		send_access(FUNC_CPU_WR, 16'h7000, 8'h3C);
		// vertical mirroring, 32KB PRG, 4KB CHR
		load_register(SEL_CONTROL, 5'h12);
		send_access(FUNC_CPU_RD, 16'hC000, 8'h00);
		send_access(FUNC_PPU_RD, 16'h1800, 8'h00);
	endtask

	task automatic test_random_settings();
		run_random(80);
		write_config(3'd0, 3'd0, 3'd0, 3'd0);
		run_random(85);
		write_config(3'd5, 3'd1, 3'd5, 3'd4);
		run_random(85);
		// out-of-range sizes and mirroring clamp; CHR RAM takes bit 0
		write_config(3'd7, 3'd6, 3'd6, 3'd7);
		tx_idle = 0;
		rx_idle = 0;
		run_random(85);
		tx_idle = 1;
		rx_idle = 1;
		write_config(3'd3, 3'd3, 3'd2, 3'd2);
		run_random(85);
		write_config(3'd2, 3'd1, 3'd3, 3'd1);
		run_random(85);
	endtask

	task automatic test_output_backpressure();
		drain_results();
		tx_idle = 0;
		longest_hold = 150;
		hold_left = longest_hold;
		run_random(40);
		tx_idle = 1;
	endtask

	initial begin
		arst_n             <= 1'b0;
		bus_req.valid      <= 1'b0;
		bus_req.func       <= FUNC_CPU_RD;
		bus_req.address    <= '0;
		bus_req.write_data <= '0;
		cfg_wr.valid       <= 1'b0;
		cfg_wr.index       <= CFG_PRG_LOG2;
		cfg_wr.data        <= '0;
		n_requests = 0;
		n_checked  = 0;
		n_errors   = 0;
		n_settings = 0;
		tx_idle    = 1;
		rx_idle    = 1;
		hold_left  = 0;
		longest_hold = 0;
		reset_translator();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_state();
		test_serial_loading();
		test_random_settings();
		test_output_backpressure();

		drain_results();
		repeat (6) @(posedge clk);
		if (expected_xlate.size() != 0)
			report_mismatch("missing results", expected_xlate.size(), 0);
		$display("run: %0d requests sent, %0d results checked, %0d mismatches",
			n_requests, n_checked, n_errors);
		$display("run: %0d cartridge settings incl. clamped writes, %0d-cycle output hold",
			n_settings, longest_hold);
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
